/* rtl/ordl_pkg.sv */
// Shared types and constants for the ordered id list with cursor.
// Holds the command and result codes and the structs passed between controller and datapath.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
package ordl_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int ID_W             = 32;

  typedef enum logic [2:0] {
    KIND_ADD      = 3'd0,
    KIND_REMOVE   = 3'd1,
    KIND_PLAY     = 3'd2,
    KIND_NEXT     = 3'd3,
    KIND_PREV     = 3'd4,
    KIND_SEARCH   = 3'd5,
    KIND_LIST_FWD = 3'd6,
    KIND_LIST_REV = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NO_CURSOR = 3'd5,
    ST_AT_END    = 3'd6,
    ST_AT_BEGIN  = 3'd7
  } status_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_FROM_HEAD,
    DP_FROM_TAIL,
    DP_FROM_CURSOR,
    DP_WALK,
    DP_SCAN_START,
    DP_SCAN,
    DP_ADD_LINK,
    DP_ADD_FINISH,
    DP_REMOVE,
    DP_SET_CURSOR
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    emit;
    status_t status;
    logic    take_id;
    logic    last;
    logic    back;
  } cmd_t;

  typedef struct packed {
    logic head_ok;
    logic tail_ok;
    logic cursor_ok;
    logic match;
    logic link_ok;
    logic full;
    logic free;
  } flags_t;

endpackage

/* rtl/ordl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the id store and both link stores; depends on nothing.
module ordl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ordl_ctrl.sv */
// Controller state machine for the ordered id list.
// Sequences each command as datapath operations; uses ordl_pkg types.
module ordl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        kind,
  input  ordl_pkg::flags_t  flags,
  output logic              busy,
  output ordl_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_SCAN,
    S_ADD_FINISH,
    S_PLAY,
    S_STEP,
    S_STEP_READ,
    S_LIST
  } state_t;

  state_t          state, state_next;
  ordl_pkg::kind_t op_kind;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.op      = ordl_pkg::DP_IDLE;
    cmd.emit    = 1'b0;
    cmd.status  = ordl_pkg::ST_OK;
    cmd.take_id = 1'b0;
    cmd.last    = 1'b1;
    cmd.back    = (op_kind == ordl_pkg::KIND_PREV) || (op_kind == ordl_pkg::KIND_LIST_REV);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = ordl_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_kind)
          ordl_pkg::KIND_ADD, ordl_pkg::KIND_REMOVE, ordl_pkg::KIND_SEARCH: begin
            if (flags.head_ok) begin
              cmd.op     = ordl_pkg::DP_FROM_HEAD;
              state_next = S_FIND;
            end else if (op_kind == ordl_pkg::KIND_ADD) begin
              cmd.op     = ordl_pkg::DP_SCAN_START;
              state_next = S_SCAN;
            end else begin
              cmd.emit   = 1'b1;
              cmd.status = ordl_pkg::ST_NOT_FOUND;
              state_next = S_IDLE;
            end
          end
          ordl_pkg::KIND_PLAY: begin
            if (flags.head_ok) begin
              cmd.op     = ordl_pkg::DP_FROM_HEAD;
              state_next = S_PLAY;
            end else begin
              cmd.emit   = 1'b1;
              cmd.status = ordl_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          ordl_pkg::KIND_NEXT, ordl_pkg::KIND_PREV: begin
            if (flags.cursor_ok) begin
              cmd.op     = ordl_pkg::DP_FROM_CURSOR;
              state_next = S_STEP;
            end else begin
              cmd.emit   = 1'b1;
              cmd.status = ordl_pkg::ST_NO_CURSOR;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (!cmd.back && flags.head_ok) begin
              cmd.op     = ordl_pkg::DP_FROM_HEAD;
              state_next = S_LIST;
            end else if (cmd.back && flags.tail_ok) begin
              cmd.op     = ordl_pkg::DP_FROM_TAIL;
              state_next = S_LIST;
            end else begin
              cmd.emit   = 1'b1;
              cmd.status = ordl_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_FIND: begin
        cmd.back = 1'b0;
        if (flags.match) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          case (op_kind)
            ordl_pkg::KIND_ADD:    cmd.status = ordl_pkg::ST_DUPLICATE;
            ordl_pkg::KIND_REMOVE: cmd.op = ordl_pkg::DP_REMOVE;
            default:               cmd.take_id = 1'b1;
          endcase
        end else if (flags.link_ok) begin
          cmd.op = ordl_pkg::DP_WALK;
        end else if (op_kind == ordl_pkg::KIND_ADD) begin
          if (flags.full) begin
            cmd.emit   = 1'b1;
            cmd.status = ordl_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.op     = ordl_pkg::DP_SCAN_START;
            state_next = S_SCAN;
          end
        end else begin
          cmd.emit   = 1'b1;
          cmd.status = ordl_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (flags.free) begin
          cmd.op     = ordl_pkg::DP_ADD_LINK;
          state_next = S_ADD_FINISH;
        end else begin
          cmd.op = ordl_pkg::DP_SCAN;
        end
      end
      S_ADD_FINISH: begin
        cmd.op     = ordl_pkg::DP_ADD_FINISH;
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_PLAY, S_STEP_READ: begin
        cmd.op      = ordl_pkg::DP_SET_CURSOR;
        cmd.emit    = 1'b1;
        cmd.take_id = 1'b1;
        state_next  = S_IDLE;
      end
      S_STEP: begin
        if (flags.link_ok) begin
          cmd.op     = ordl_pkg::DP_WALK;
          state_next = S_STEP_READ;
        end else begin
          cmd.emit   = 1'b1;
          cmd.status = cmd.back ? ordl_pkg::ST_AT_BEGIN : ordl_pkg::ST_AT_END;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        cmd.emit    = 1'b1;
        cmd.take_id = 1'b1;
        cmd.last    = !flags.link_ok;
        if (flags.link_ok) begin
          cmd.op = ordl_pkg::DP_WALK;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == S_IDLE && start) begin
      op_kind <= ordl_pkg::kind_t'(kind);
    end
  end

endmodule

/* rtl/ordl_datapath.sv */
// Datapath of the ordered id list: id and link memories, slot-used bits,
// head/tail/cursor pointers and the result register. Uses ordl_pkg, ordl_ram.
module ordl_datapath #(
  parameter int CAPACITY = ordl_pkg::CAPACITY_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ordl_pkg::cmd_t                    cmd,
  input  logic signed [ordl_pkg::ID_W-1:0]  song_id,
  output ordl_pkg::flags_t                  flags,
  output logic                              valid,
  output logic [2:0]                        status,
  output logic signed [ordl_pkg::ID_W-1:0]  result_id,
  output logic                              last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [CAPACITY-1:0] used;
  logic [LW-1:0]       head, tail, cursor, count;
  logic [LW-1:0]       ptr;
  logic [SW-1:0]       scan;
  logic signed [ordl_pkg::ID_W-1:0] id;

  logic [SW-1:0]       raddr;
  logic [ordl_pkg::ID_W-1:0] ids_rdata;
  logic [LW-1:0]       fwd_rdata, bwd_rdata, link;
  logic                ids_we, fwd_we, bwd_we;
  logic [SW-1:0]       fwd_waddr, bwd_waddr;
  logic [LW-1:0]       fwd_wdata, bwd_wdata;

  function automatic logic slot_ok(input logic [LW-1:0] s, input logic [CAPACITY-1:0] u);
    slot_ok = (s < NIL) && u[s[SW-1:0]];
  endfunction

  assign link            = cmd.back ? bwd_rdata : fwd_rdata;
  assign flags.head_ok   = slot_ok(head, used);
  assign flags.tail_ok   = slot_ok(tail, used);
  assign flags.cursor_ok = slot_ok(cursor, used);
  assign flags.match     = (ids_rdata == id);
  assign flags.link_ok   = slot_ok(link, used);
  assign flags.full      = (count == NIL);
  assign flags.free      = !used[scan];

  always_comb begin
    case (cmd.op)
      ordl_pkg::DP_FROM_HEAD:   raddr = head[SW-1:0];
      ordl_pkg::DP_FROM_TAIL:   raddr = tail[SW-1:0];
      ordl_pkg::DP_FROM_CURSOR: raddr = cursor[SW-1:0];
      ordl_pkg::DP_WALK:        raddr = link[SW-1:0];
      default:                  raddr = ptr[SW-1:0];
    endcase

    ids_we    = (cmd.op == ordl_pkg::DP_ADD_LINK);
    fwd_we    = 1'b0;
    fwd_waddr = scan;
    fwd_wdata = NIL;
    bwd_we    = 1'b0;
    bwd_waddr = scan;
    bwd_wdata = tail;
    case (cmd.op)
      ordl_pkg::DP_ADD_LINK: begin
        fwd_we    = flags.tail_ok;
        fwd_waddr = tail[SW-1:0];
        fwd_wdata = LW'(scan);
        bwd_we    = 1'b1;
      end
      ordl_pkg::DP_ADD_FINISH: begin
        fwd_we = 1'b1;
      end
      ordl_pkg::DP_REMOVE: begin
        fwd_we    = slot_ok(bwd_rdata, used);
        fwd_waddr = bwd_rdata[SW-1:0];
        fwd_wdata = fwd_rdata;
        bwd_we    = slot_ok(fwd_rdata, used);
        bwd_waddr = fwd_rdata[SW-1:0];
        bwd_wdata = bwd_rdata;
      end
      default: begin
      end
    endcase
  end

  ordl_ram #(.WIDTH(ordl_pkg::ID_W), .DEPTH(CAPACITY)) u_ids (
    .clk(clk), .we(ids_we), .waddr(scan), .wdata(id), .raddr(raddr), .rdata(ids_rdata)
  );

  ordl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(raddr), .rdata(fwd_rdata)
  );

  ordl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_bwd (
    .clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
    .raddr(raddr), .rdata(bwd_rdata)
  );

  // List state; the removed slot sits at ptr with its links on the read port.
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      head   <= NIL;
      tail   <= NIL;
      cursor <= NIL;
      count  <= '0;
      valid  <= 1'b0;
    end else begin
      valid <= cmd.emit;
      case (cmd.op)
        ordl_pkg::DP_ADD_FINISH: begin
          used[scan] <= 1'b1;
          if (!flags.tail_ok) begin
            head <= LW'(scan);
          end
          tail  <= LW'(scan);
          count <= count + 1'b1;
        end
        ordl_pkg::DP_REMOVE: begin
          used[ptr[SW-1:0]] <= 1'b0;
          if (head == ptr) begin
            head <= slot_ok(fwd_rdata, used) ? fwd_rdata : NIL;
          end
          if (tail == ptr) begin
            tail <= slot_ok(bwd_rdata, used) ? bwd_rdata : NIL;
          end
          if (cursor == ptr) begin
            cursor <= NIL;
          end
          if (count != '0) begin
            count <= count - 1'b1;
          end
        end
        ordl_pkg::DP_SET_CURSOR: begin
          cursor <= ptr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ordl_pkg::DP_LOAD:        id   <= song_id;
      ordl_pkg::DP_FROM_HEAD:   ptr  <= head;
      ordl_pkg::DP_FROM_TAIL:   ptr  <= tail;
      ordl_pkg::DP_FROM_CURSOR: ptr  <= cursor;
      ordl_pkg::DP_WALK:        ptr  <= link;
      ordl_pkg::DP_SCAN_START:  scan <= '0;
      ordl_pkg::DP_SCAN:        scan <= scan + 1'b1;
      default: begin
      end
    endcase
    if (cmd.emit) begin
      status    <= cmd.status;
      result_id <= cmd.take_id ? ids_rdata : '0;
      last      <= cmd.last;
    end
  end

endmodule

/* rtl/ordered_id_list_with_cursor.sv */
// A command's first word is on the outputs once the entries it needs have been read,
// one read at a time on the shared memory read port.
// Add then scans the used bits for the lowest free slot, links the new entry and finishes it.
// Listing then delivers one word per cycle; one command is in flight at a time.
// Reset (rst, synchronous) empties the list at once: no clearing pass is run.
// The receiver cannot stall; busy drops in the cycle that shows a command's last word.
module ordered_id_list_with_cursor #(
  parameter int CAPACITY = ordl_pkg::CAPACITY_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [2:0]                       kind,
  input  logic signed [ordl_pkg::ID_W-1:0] song_id,
  output logic                             busy,
  output logic                             valid,
  output logic [2:0]                       status,
  output logic signed [ordl_pkg::ID_W-1:0] result_id,
  output logic                             last
);

  // The controller decides what happens each cycle; the datapath owns all
  // list storage and reports back the few conditions the controller needs.
  ordl_pkg::cmd_t   cmd;
  ordl_pkg::flags_t flags;

  ordl_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .flags(flags),
    .busy(busy),
    .cmd(cmd)
  );

  // The datapath walks the chain one link per cycle: the link read out of
  // memory is fed straight back as the next read address.
  ordl_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .song_id(song_id),
    .flags(flags),
    .valid(valid),
    .status(status),
    .result_id(result_id),
    .last(last)
  );

endmodule

/* rtl/ordl_checker.sv */
// Port-level checks for the ordered id list, bound to the top level.
// Depends only on the top level's ports.
module ordl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid,
  input logic last
);

  // A taken command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command taken but block not busy");

  // Words of a listing come back to back until the one marked last.
  a_list_contiguous: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid) else $error("gap inside a multi-word result");

  // The block is busy exactly while more words of the command are due.
  a_busy_matches_last: assert property (@(posedge clk) disable iff (rst)
    valid |-> (busy == !last)) else $error("busy disagrees with last marker");

  // An idle block produces no word in the next cycle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !valid) else $error("word produced without a command");

  // Reset leaves the block idle with no word pending.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !valid && !busy) else $error("block not idle after reset");

endmodule

bind ordered_id_list_with_cursor ordl_checker u_ordl_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .valid(valid),
  .last(last)
);
